// ===== hw/rtl/cnts_pkg.sv =====
package cnts_pkg;

    localparam int YEAR_ARG_W = 13;

    localparam logic [2:0] REG_SECOND_MASK    = 3'd0;
    localparam logic [2:0] REG_MINUTE_MASK    = 3'd1;
    localparam logic [2:0] REG_HOUR_MASK      = 3'd2;
    localparam logic [2:0] REG_MONTH_DAY_MASK = 3'd3;
    localparam logic [2:0] REG_MONTH_MASK     = 3'd4;
    localparam logic [2:0] REG_WEEKDAY_MASK   = 3'd5;

    typedef enum logic [3:0] {
        S_IDLE,
        S_START,
        S_WALK_YEAR,
        S_WALK_MONTH,
        S_WALK_DAY,
        S_DAY,
        S_TIME,
        S_FOUND,
        S_MISS
    } t_state;

    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_WALK_YEAR,
        CMD_WALK_MONTH,
        CMD_WALK_DAY,
        CMD_TIME_STEP,
        CMD_NEXT_DAY,
        CMD_FOUND,
        CMD_MISS
    } t_cmd;

    typedef struct packed {
        logic start_bad;
        logic year_done;
        logic month_done;
        logic day_done;
        logic day_ok;
        logic year_over;
        logic time_match;
        logic time_fail;
        logic out_free;
    } t_status;

    typedef struct packed {
        logic       found;
        logic [5:0] idx;
    } t_find;

    // year counted from 1900
    function automatic logic is_leap(input logic [YEAR_ARG_W-1:0] y);
        int  yi;
        logic century;
        logic quad;
        yi = int'(y);
        century = 1'b0;
        quad = 1'b0;
        for (int k = 0; k < 41; k++) begin
            if (yi == k * 100) century = 1'b1;
            if (yi == k * 400 + 100) quad = 1'b1;
        end
        return (y[1:0] == 2'd0) && (!century || quad);
    endfunction

    function automatic logic [4:0] days_in_month(input logic [YEAR_ARG_W-1:0] y,
                                                 input logic [3:0] mo);
        logic [4:0] len;
        case (mo)
            4'd1:    len = is_leap(y) ? 5'd29 : 5'd28;
            4'd3, 4'd5, 4'd8, 4'd10: len = 5'd30;
            default: len = 5'd31;
        endcase
        return len;
    endfunction

    function automatic logic [2:0] wd_add(input logic [2:0] wd, input logic [1:0] k);
        logic [3:0] t;
        t = {1'b0, wd} + {2'b00, k};
        return (t >= 4'd7) ? 3'(t - 4'd7) : t[2:0];
    endfunction

    // lowest set bit at or above lo
    function automatic t_find find_from(input logic [63:0] mask, input logic [5:0] lo);
        t_find r;
        r.found = 1'b0;
        r.idx = 6'd0;
        for (int i = 63; i >= 0; i--) begin
            if (mask[i] && (i >= int'(lo))) begin
                r.found = 1'b1;
                r.idx = 6'(i);
            end
        end
        return r;
    endfunction

endpackage

// ===== hw/rtl/cron_next_trigger_search.sv =====
// next matching time of a cron style schedule
// slave stream: one beat carries a start date and time; tready is high only
//   while no search runs
// master stream: one beat per request with the first second after the start
//   whose second, minute, hour, day of month, month and weekday are enabled;
//   tuser flags that no such second exists by the end of the last year
// cfg channel: writes one of the six masks by index, taken in every cycle;
//   the user must see it used only while no search runs; nothing checks it
// search: the weekday is reckoned by walking from the first of january of
//   year zero by year, by month and by day up to the start date; then each
//   day is tested against the day masks, and on a day that passes them the
//   hour, minute and second are stepped to the next enabled values
// one request is searched at a time; the result register frees the engine,
//   so a stalled receiver only holds the next result
// reset sets all masks to all ones and empties the result register
module cron_next_trigger_search #(
    parameter int YEAR_BITS = 8
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_s_axis_tvalid,
    output logic                    o_s_axis_tready,
    // start_second, start_minute, start_hour, start_day, start_month, start_year
    input  logic [((26 + YEAR_BITS + 7) / 8) * 8 - 1:0] i_s_axis_tdata,
    output logic                    o_m_axis_tvalid,
    input  logic                    i_m_axis_tready,
    // next_second, next_minute, next_hour, next_day, next_month, next_year,
    // next_weekday
    output logic [((29 + YEAR_BITS + 7) / 8) * 8 - 1:0] o_m_axis_tdata,
    // not_found
    output logic                    o_m_axis_tuser,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [2:0]              i_cfg_index,
    input  logic [59:0]             i_cfg_data
);

    localparam int IN_BITS = 26 + YEAR_BITS;
    localparam int OUT_BITS = 29 + YEAR_BITS;
    localparam int OUT_W = ((OUT_BITS + 7) / 8) * 8;

    cnts_pkg::t_cmd    w_cmd;
    cnts_pkg::t_status w_status;

    logic [5:0]           w_s, w_m;
    logic [4:0]           w_h, w_d;
    logic [3:0]           w_mo;
    logic [YEAR_BITS-1:0] w_y;
    logic [2:0]           w_wd;

    assign o_cfg_ready = 1'b1;

    cnts_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    cnts_dp #(
        .YEAR_BITS (YEAR_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_status       (w_status),
        .i_cfg_we       (i_cfg_valid),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_start_second (i_s_axis_tdata[5:0]),
        .i_start_minute (i_s_axis_tdata[11:6]),
        .i_start_hour   (i_s_axis_tdata[16:12]),
        .i_start_day    (i_s_axis_tdata[21:17]),
        .i_start_month  (i_s_axis_tdata[25:22]),
        .i_start_year   (i_s_axis_tdata[IN_BITS-1:26]),
        .i_out_ready    (i_m_axis_tready),
        .o_out_valid    (o_m_axis_tvalid),
        .o_next_second  (w_s),
        .o_next_minute  (w_m),
        .o_next_hour    (w_h),
        .o_next_day     (w_d),
        .o_next_month   (w_mo),
        .o_next_year    (w_y),
        .o_next_weekday (w_wd),
        .o_not_found    (o_m_axis_tuser)
    );

    assign o_m_axis_tdata = OUT_W'({w_wd, w_y, w_mo, w_d, w_h, w_m, w_s});

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> !o_s_axis_tready)
        else $error("input taken while a search runs");

    a_miss_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser |-> o_m_axis_tdata == '0)
        else $error("miss result carries data");

    a_found_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tuser |->
            w_s < 6'd60 && w_m < 6'd60 && w_h < 5'd24 && w_d != 5'd0
            && w_mo < 4'd12 && w_wd < 3'd7)
        else $error("result time out of range");
`endif

endmodule

// ===== hw/rtl/cnts_ctrl.sv =====
module cnts_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  cnts_pkg::t_status  i_status,
    output cnts_pkg::t_cmd     o_cmd
);

    cnts_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cnts_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            cnts_pkg::S_IDLE: begin
                if (i_in_valid) n_state = cnts_pkg::S_START;
            end
            cnts_pkg::S_START: begin
                n_state = i_status.start_bad ? cnts_pkg::S_MISS : cnts_pkg::S_WALK_YEAR;
            end
            cnts_pkg::S_WALK_YEAR: begin
                if (i_status.year_done) n_state = cnts_pkg::S_WALK_MONTH;
            end
            cnts_pkg::S_WALK_MONTH: begin
                if (i_status.month_done) n_state = cnts_pkg::S_WALK_DAY;
            end
            cnts_pkg::S_WALK_DAY: begin
                if (i_status.day_done) n_state = cnts_pkg::S_DAY;
            end
            cnts_pkg::S_DAY: begin
                if (i_status.year_over) n_state = cnts_pkg::S_MISS;
                else if (i_status.day_ok) n_state = cnts_pkg::S_TIME;
            end
            cnts_pkg::S_TIME: begin
                if (i_status.time_match) n_state = cnts_pkg::S_FOUND;
                else if (i_status.time_fail) n_state = cnts_pkg::S_DAY;
            end
            cnts_pkg::S_FOUND, cnts_pkg::S_MISS: begin
                if (i_status.out_free) n_state = cnts_pkg::S_IDLE;
            end
            default: n_state = cnts_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = cnts_pkg::CMD_NONE;
        o_in_ready = 1'b0;
        case (r_state)
            cnts_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) o_cmd = cnts_pkg::CMD_LOAD;
            end
            cnts_pkg::S_WALK_YEAR: begin
                if (!i_status.year_done) o_cmd = cnts_pkg::CMD_WALK_YEAR;
            end
            cnts_pkg::S_WALK_MONTH: begin
                if (!i_status.month_done) o_cmd = cnts_pkg::CMD_WALK_MONTH;
            end
            cnts_pkg::S_WALK_DAY: begin
                if (!i_status.day_done) o_cmd = cnts_pkg::CMD_WALK_DAY;
            end
            cnts_pkg::S_DAY: begin
                if (!i_status.year_over && !i_status.day_ok) o_cmd = cnts_pkg::CMD_NEXT_DAY;
            end
            cnts_pkg::S_TIME: begin
                if (i_status.time_match) o_cmd = cnts_pkg::CMD_NONE;
                else if (i_status.time_fail) o_cmd = cnts_pkg::CMD_NEXT_DAY;
                else o_cmd = cnts_pkg::CMD_TIME_STEP;
            end
            cnts_pkg::S_FOUND: begin
                if (i_status.out_free) o_cmd = cnts_pkg::CMD_FOUND;
            end
            cnts_pkg::S_MISS: begin
                if (i_status.out_free) o_cmd = cnts_pkg::CMD_MISS;
            end
            default: o_cmd = cnts_pkg::CMD_NONE;
        endcase
    end

endmodule

// ===== hw/rtl/cnts_dp.sv =====
module cnts_dp #(
    parameter int YEAR_BITS = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  cnts_pkg::t_cmd       i_cmd,
    output cnts_pkg::t_status    o_status,
    input  logic                 i_cfg_we,
    input  logic [2:0]           i_cfg_index,
    input  logic [59:0]          i_cfg_data,
    input  logic [5:0]           i_start_second,
    input  logic [5:0]           i_start_minute,
    input  logic [4:0]           i_start_hour,
    input  logic [4:0]           i_start_day,
    input  logic [3:0]           i_start_month,
    input  logic [YEAR_BITS-1:0] i_start_year,
    input  logic                 i_out_ready,
    output logic                 o_out_valid,
    output logic [5:0]           o_next_second,
    output logic [5:0]           o_next_minute,
    output logic [4:0]           o_next_hour,
    output logic [4:0]           o_next_day,
    output logic [3:0]           o_next_month,
    output logic [YEAR_BITS-1:0] o_next_year,
    output logic [2:0]           o_next_weekday,
    output logic                 o_not_found
);

    localparam int YW = YEAR_BITS + 1;
    localparam logic [YW-1:0] YEAR_LAST = YW'((1 << YEAR_BITS) - 1);
    localparam int AW = cnts_pkg::YEAR_ARG_W;

    logic [59:0] r_sec_mask, r_min_mask;
    logic [23:0] r_hr_mask;
    logic [30:0] r_mday_mask;
    logic [11:0] r_mon_mask;
    logic [6:0]  r_wday_mask;

    logic [5:0]    r_s, r_m;
    logic [4:0]    r_h, r_d, r_cd;
    logic [3:0]    r_mo, r_cmo;
    logic [YW-1:0] r_y, r_cy;
    logic [2:0]    r_wd;

    logic                 r_out_valid;
    logic [5:0]           r_o_s, r_o_m;
    logic [4:0]           r_o_h, r_o_d;
    logic [3:0]           r_o_mo;
    logic [YEAR_BITS-1:0] r_o_y;
    logic [2:0]           r_o_wd;
    logic                 r_o_nf;

    // start normalization
    logic [6:0]    s1, m1;
    logic [5:0]    h1, dd;
    logic          cs, cm, ch, mo_hi;
    logic [5:0]    ns, nm;
    logic [4:0]    nh, nd;
    logic [3:0]    mo_a, mo_p, mo_n, nmo;
    logic [YW-1:0] y_a, y_p, y_n, ny;
    logic [4:0]    dim_c, dim_p;

    always_comb begin
        s1 = {1'b0, i_start_second} + 7'd1;
        cs = s1 >= 7'd60;
        ns = cs ? 6'(s1 - 7'd60) : s1[5:0];
        m1 = {1'b0, i_start_minute} + {6'd0, cs};
        cm = m1 >= 7'd60;
        nm = cm ? 6'(m1 - 7'd60) : m1[5:0];
        h1 = {1'b0, i_start_hour} + {5'd0, cm};
        ch = h1 >= 6'd24;
        nh = ch ? 5'(h1 - 6'd24) : h1[4:0];
        mo_hi = i_start_month >= 4'd12;
        mo_a = mo_hi ? 4'(i_start_month - 4'd12) : i_start_month;
        y_a = {1'b0, i_start_year} + {{(YW-1){1'b0}}, mo_hi};
        dd = {1'b0, i_start_day} + {5'd0, ch};
        mo_p = (mo_a == 4'd0) ? 4'd11 : 4'(mo_a - 4'd1);
        y_p = (mo_a == 4'd0) ? YW'(y_a - 1'b1) : y_a;
        mo_n = (mo_a == 4'd11) ? 4'd0 : 4'(mo_a + 4'd1);
        y_n = (mo_a == 4'd11) ? YW'(y_a + 1'b1) : y_a;
        dim_c = cnts_pkg::days_in_month(AW'(y_a), mo_a);
        dim_p = cnts_pkg::days_in_month(AW'(y_p), mo_p);
        ny = y_a;
        nmo = mo_a;
        nd = dd[4:0];
        if (dd == 6'd0) begin
            if (y_a == '0 && mo_a == 4'd0) begin
                ns = 6'd0;
                nm = 6'd0;
                nh = 5'd0;
                nd = 5'd1;
            end else begin
                ny = y_p;
                nmo = mo_p;
                nd = dim_p;
            end
        end else if (dd > {1'b0, dim_c}) begin
            ny = y_n;
            nmo = mo_n;
            nd = 5'(dd - {1'b0, dim_c});
        end
    end

    // time of day search
    cnts_pkg::t_find hf, mf, sf;
    logic hr_ok, min_ok, sec_ok;
    logic [4:0] dim_r, dim_w;

    always_comb begin
        hf = cnts_pkg::find_from({40'd0, r_hr_mask}, {1'b0, r_h});
        mf = cnts_pkg::find_from({4'd0, r_min_mask}, r_m);
        sf = cnts_pkg::find_from({4'd0, r_sec_mask}, r_s);
        hr_ok = r_hr_mask[r_h];
        min_ok = r_min_mask[r_m];
        sec_ok = r_sec_mask[r_s];
        dim_r = cnts_pkg::days_in_month(AW'(r_y), r_mo);
        dim_w = cnts_pkg::days_in_month(AW'(r_y), r_cmo);
    end

    always_comb begin
        o_status.start_bad = (r_sec_mask == '0) || (r_min_mask == '0) || (r_hr_mask == '0)
                             || (r_y > YEAR_LAST);
        o_status.year_done = r_cy == r_y;
        o_status.month_done = r_cmo == r_mo;
        o_status.day_done = r_cd == r_d;
        o_status.day_ok = r_mon_mask[r_mo] && r_mday_mask[5'(r_d - 5'd1)] && r_wday_mask[r_wd];
        o_status.year_over = r_y > YEAR_LAST;
        o_status.time_match = hr_ok && min_ok && sec_ok;
        o_status.time_fail = (!hr_ok && !hf.found)
                             || (hr_ok && !min_ok && !mf.found && r_h == 5'd23)
                             || (hr_ok && min_ok && !sec_ok && !sf.found
                                 && r_m == 6'd59 && r_h == 5'd23);
        o_status.out_free = !r_out_valid || i_out_ready;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sec_mask <= '1;
            r_min_mask <= '1;
            r_hr_mask <= '1;
            r_mday_mask <= '1;
            r_mon_mask <= '1;
            r_wday_mask <= '1;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                cnts_pkg::REG_SECOND_MASK:    r_sec_mask <= i_cfg_data;
                cnts_pkg::REG_MINUTE_MASK:    r_min_mask <= i_cfg_data;
                cnts_pkg::REG_HOUR_MASK:      r_hr_mask <= i_cfg_data[23:0];
                cnts_pkg::REG_MONTH_DAY_MASK: r_mday_mask <= i_cfg_data[30:0];
                cnts_pkg::REG_MONTH_MASK:     r_mon_mask <= i_cfg_data[11:0];
                cnts_pkg::REG_WEEKDAY_MASK:   r_wday_mask <= i_cfg_data[6:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd)
            cnts_pkg::CMD_LOAD: begin
                r_s <= ns;
                r_m <= nm;
                r_h <= nh;
                r_d <= nd;
                r_mo <= nmo;
                r_y <= ny;
                r_cy <= '0;
                r_cmo <= 4'd0;
                r_cd <= 5'd1;
                r_wd <= 3'd1;
            end
            cnts_pkg::CMD_WALK_YEAR: begin
                r_wd <= cnts_pkg::wd_add(r_wd, cnts_pkg::is_leap(AW'(r_cy)) ? 2'd2 : 2'd1);
                r_cy <= YW'(r_cy + 1'b1);
            end
            cnts_pkg::CMD_WALK_MONTH: begin
                r_wd <= cnts_pkg::wd_add(r_wd, 2'(dim_w - 5'd28));
                r_cmo <= 4'(r_cmo + 4'd1);
            end
            cnts_pkg::CMD_WALK_DAY: begin
                r_wd <= cnts_pkg::wd_add(r_wd, 2'd1);
                r_cd <= 5'(r_cd + 5'd1);
            end
            cnts_pkg::CMD_NEXT_DAY: begin
                r_s <= 6'd0;
                r_m <= 6'd0;
                r_h <= 5'd0;
                r_wd <= cnts_pkg::wd_add(r_wd, 2'd1);
                if (r_d == dim_r) begin
                    r_d <= 5'd1;
                    if (r_mo == 4'd11) begin
                        r_mo <= 4'd0;
                        r_y <= YW'(r_y + 1'b1);
                    end else begin
                        r_mo <= 4'(r_mo + 4'd1);
                    end
                end else begin
                    r_d <= 5'(r_d + 5'd1);
                end
            end
            cnts_pkg::CMD_TIME_STEP: begin
                if (!hr_ok) begin
                    r_h <= hf.idx[4:0];
                    r_m <= 6'd0;
                    r_s <= 6'd0;
                end else if (!min_ok) begin
                    r_s <= 6'd0;
                    if (mf.found) begin
                        r_m <= mf.idx;
                    end else begin
                        r_m <= 6'd0;
                        r_h <= 5'(r_h + 5'd1);
                    end
                end else if (sf.found) begin
                    r_s <= sf.idx;
                end else begin
                    r_s <= 6'd0;
                    if (r_m == 6'd59) begin
                        r_m <= 6'd0;
                        r_h <= 5'(r_h + 5'd1);
                    end else begin
                        r_m <= 6'(r_m + 6'd1);
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd == cnts_pkg::CMD_FOUND || i_cmd == cnts_pkg::CMD_MISS) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd == cnts_pkg::CMD_FOUND) begin
            r_o_s <= r_s;
            r_o_m <= r_m;
            r_o_h <= r_h;
            r_o_d <= r_d;
            r_o_mo <= r_mo;
            r_o_y <= r_y[YEAR_BITS-1:0];
            r_o_wd <= r_wd;
            r_o_nf <= 1'b0;
        end else if (i_cmd == cnts_pkg::CMD_MISS) begin
            r_o_s <= '0;
            r_o_m <= '0;
            r_o_h <= '0;
            r_o_d <= '0;
            r_o_mo <= '0;
            r_o_y <= '0;
            r_o_wd <= '0;
            r_o_nf <= 1'b1;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_next_second = r_o_s;
    assign o_next_minute = r_o_m;
    assign o_next_hour = r_o_h;
    assign o_next_day = r_o_d;
    assign o_next_month = r_o_mo;
    assign o_next_year = r_o_y;
    assign o_next_weekday = r_o_wd;
    assign o_not_found = r_o_nf;

endmodule

// ===== verif/cnts_checker.sv =====
`timescale 1ns / 1ps

module cnts_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_valid,
    input  logic        i_s_ready,
    input  logic [39:0] i_s_data,
    input  logic        i_m_valid,
    input  logic        i_m_ready,
    input  logic [39:0] i_m_data,
    input  logic        i_m_user,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [59:0] i_cfg_data,
    output int          o_errors,
    output int          o_pending
);

    localparam int LAST_YEAR = 255;

    typedef struct {
        logic [5:0] sec;
        logic [5:0] min;
        logic [4:0] hour;
        logic [4:0] day;
        logic [3:0] month;
        logic [7:0] year;
        logic [2:0] wday;
        logic       none;
    } t_trigger;

    logic [59:0] sec_en, min_en;
    logic [23:0] hour_en;
    logic [30:0] mday_en;
    logic [11:0] month_en;
    logic [6:0]  wday_en;
    t_trigger    trigger_q[$];
    int          errors = 0;

    assign o_errors  = errors;
    assign o_pending = trigger_q.size();

    function automatic bit leap_year(int y);
        int g;
        g = y + 1900;
        return (g % 4 == 0) && ((g % 100 != 0) || (g % 400 == 0));
    endfunction

    function automatic int month_days(int y, int mo);
        int lens[12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
        if (mo == 1 && leap_year(y)) return 29;
        return lens[mo % 12];
    endfunction

    function automatic int leaps_upto(int g);
        return g / 4 - g / 100 + g / 400;
    endfunction

    function automatic t_trigger next_trigger(logic [39:0] d);
        t_trigger r;
        int s0, m0, h0, d0, mo, y, tod, lo_h, lo_m, lo_s, wd, dd;
        longint dayidx, secs, len;
        bit first;
        s0 = d[5:0];
        m0 = d[11:6];
        h0 = d[16:12];
        d0 = d[21:17];
        mo = d[25:22];
        y = d[33:26];
        r = '{default: '0};
        r.none = 1'b1;
        first = 1;
        if (mo >= 12) begin
            mo -= 12;
            y += 1;
        end
        dayidx = longint'(y) * 365 + leaps_upto(y + 1899) - leaps_upto(1899);
        for (int k = 0; k < mo; k++) dayidx += month_days(y, k);
        dayidx += d0 - 1;
        secs = dayidx * 86400 + h0 * 3600 + m0 * 60 + s0 + 1;
        if (secs < 0) secs = 0;
        dayidx = secs / 86400;
        tod = int'(secs % 86400);
        lo_h = tod / 3600;
        lo_m = (tod / 60) % 60;
        lo_s = tod % 60;
        wd = int'((dayidx + 1) % 7);
        y = 0;
        while (y <= LAST_YEAR + 1) begin
            len = leap_year(y) ? 366 : 365;
            if (dayidx < len) break;
            dayidx -= len;
            y++;
        end
        mo = 0;
        while (mo < 11 && dayidx >= month_days(y, mo)) begin
            dayidx -= month_days(y, mo);
            mo++;
        end
        dd = int'(dayidx) + 1;
        if (sec_en == 0 || min_en == 0 || hour_en == 0) return r;
        while (y <= LAST_YEAR) begin
            if (month_en[mo] && mday_en[dd-1] && wday_en[wd]) begin
                int bh, bm, bs;
                bh = first ? lo_h : 0;
                bm = first ? lo_m : 0;
                bs = first ? lo_s : 0;
                for (int hh = bh; hh < 24; hh++) begin
                    if (!hour_en[hh]) continue;
                    for (int mm = (hh == bh) ? bm : 0; mm < 60; mm++) begin
                        if (!min_en[mm]) continue;
                        for (int ss = (hh == bh && mm == bm) ? bs : 0; ss < 60; ss++) begin
                            if (sec_en[ss]) begin
                                r.sec = ss;
                                r.min = mm;
                                r.hour = hh;
                                r.day = dd;
                                r.month = mo;
                                r.year = y;
                                r.wday = wd;
                                r.none = 1'b0;
                                return r;
                            end
                        end
                    end
                end
            end
            first = 0;
            dd++;
            if (dd > month_days(y, mo)) begin
                dd = 1;
                mo++;
                if (mo == 12) begin
                    mo = 0;
                    y++;
                end
            end
            wd = (wd + 1) % 7;
        end
        return r;
    endfunction

    task automatic report(string field, int want, int got);
        $display("mismatch on %s at %0t: expected %0d, got %0d", field, $time, want, got);
        errors++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            sec_en <= '1;
            min_en <= '1;
            hour_en <= '1;
            mday_en <= '1;
            month_en <= '1;
            wday_en <= '1;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    cnts_pkg::REG_SECOND_MASK:    sec_en <= i_cfg_data;
                    cnts_pkg::REG_MINUTE_MASK:    min_en <= i_cfg_data;
                    cnts_pkg::REG_HOUR_MASK:      hour_en <= i_cfg_data[23:0];
                    cnts_pkg::REG_MONTH_DAY_MASK: mday_en <= i_cfg_data[30:0];
                    cnts_pkg::REG_MONTH_MASK:     month_en <= i_cfg_data[11:0];
                    cnts_pkg::REG_WEEKDAY_MASK:   wday_en <= i_cfg_data[6:0];
                    default: ;
                endcase
            end
            if (i_m_valid && i_m_ready) begin
                if (trigger_q.size() == 0) begin
                    report("unexpected beat", 0, 1);
                end else begin
                    t_trigger w;
                    w = trigger_q.pop_front();
                    if (i_m_data[5:0] != w.sec) report("next_second", w.sec, i_m_data[5:0]);
                    if (i_m_data[11:6] != w.min) report("next_minute", w.min, i_m_data[11:6]);
                    if (i_m_data[16:12] != w.hour) report("next_hour", w.hour, i_m_data[16:12]);
                    if (i_m_data[21:17] != w.day) report("next_day", w.day, i_m_data[21:17]);
                    if (i_m_data[25:22] != w.month)
                        report("next_month", w.month, i_m_data[25:22]);
                    if (i_m_data[33:26] != w.year) report("next_year", w.year, i_m_data[33:26]);
                    if (i_m_data[36:34] != w.wday)
                        report("next_weekday", w.wday, i_m_data[36:34]);
                    if (i_m_user != w.none) report("not_found", w.none, i_m_user);
                end
            end
            if (i_s_valid && i_s_ready) trigger_q.push_back(next_trigger(i_s_data));
        end
    end

endmodule

// ===== verif/tb_cron_next_trigger_search.sv =====
`timescale 1ns / 1ps

module tb_cron_next_trigger_search;

    localparam logic [2:0] REG_SPARE_LO = 3'd6;
    localparam logic [2:0] REG_SPARE_HI = 3'd7;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [39:0] s_data = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [39:0] m_data;
    logic        m_user;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [59:0] cfg_data = '0;
    int          errors;
    int          pending;
    bit          quiet = 0;
    int          stall_left = 0;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    cron_next_trigger_search #(.YEAR_BITS(8)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_axis_tvalid(s_valid), .o_s_axis_tready(s_ready), .i_s_axis_tdata(s_data),
        .o_m_axis_tvalid(m_valid), .i_m_axis_tready(m_ready),
        .o_m_axis_tdata(m_data), .o_m_axis_tuser(m_user),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data)
    );

    cnts_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_valid(s_valid), .i_s_ready(s_ready), .i_s_data(s_data),
        .i_m_valid(m_valid), .i_m_ready(m_ready), .i_m_data(m_data), .i_m_user(m_user),
        .i_cfg_valid(cfg_valid), .i_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .o_errors(errors), .o_pending(pending)
    );

    // receiver stalls
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_ready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 9) == 0) begin
            stall_left <= $urandom_range(0, 14);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    task automatic write_mask(logic [2:0] idx, logic [59:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge i_clk);
        while (!cfg_ready) @(posedge i_clk);
        cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_masks(logic [59:0] sm, logic [59:0] mm, logic [23:0] hm,
                             logic [30:0] dm, logic [11:0] mom, logic [6:0] wm);
        write_mask(cnts_pkg::REG_SECOND_MASK, sm);
        write_mask(cnts_pkg::REG_MINUTE_MASK, mm);
        write_mask(cnts_pkg::REG_HOUR_MASK, {36'd0, hm});
        write_mask(cnts_pkg::REG_MONTH_DAY_MASK, {29'd0, dm});
        write_mask(cnts_pkg::REG_MONTH_MASK, {48'd0, mom});
        write_mask(cnts_pkg::REG_WEEKDAY_MASK, {53'd0, wm});
    endtask

    task automatic send_start(int sec, int min, int hr, int day, int mon, int yr);
        s_valid <= 1'b1;
        s_data <= {6'd0, 8'(yr), 4'(mon), 5'(day), 5'(hr), 6'(min), 6'(sec)};
        @(posedge i_clk);
        while (!s_ready) @(posedge i_clk);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
    endtask

    task automatic drain;
        s_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic send_random;
        int sec, min, hr, day, mon;
        sec = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 63) : $urandom_range(0, 59);
        min = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 63) : $urandom_range(0, 59);
        hr = ($urandom_range(0, 7) == 0) ? $urandom_range(24, 31) : $urandom_range(0, 23);
        day = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 31);
        mon = ($urandom_range(0, 7) == 0) ? $urandom_range(12, 15) : $urandom_range(0, 11);
        send_start(sec, min, hr, day, mon, $urandom_range(0, 255));
    endtask

    function automatic logic [59:0] some_bits(int width);
        logic [63:0] v;
        v = {$urandom, $urandom};
        v = v & ((64'd1 << width) - 1);
        v[$urandom_range(0, width - 1)] = 1'b1;
        return v[59:0];
    endfunction

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_start(0, 0, 0, 1, 0, 0);
        send_start(59, 59, 23, 31, 11, 255);
        send_start(63, 63, 31, 31, 1, 0);
        send_start(0, 0, 0, 0, 0, 0);
        send_start(59, 59, 23, 28, 1, 100);
        send_start(59, 59, 23, 28, 1, 0);
        send_start(30, 30, 12, 15, 15, 255);
        send_start(10, 20, 5, 31, 3, 124);
        drain();

        set_masks(60'd1 << 59, 60'd1, 24'd1 << 23, 31'd1 << 30, 12'd1 << 11, 7'd1);
        send_start(0, 0, 0, 1, 0, 0);
        send_start(59, 59, 23, 30, 11, 240);
        send_start(0, 0, 0, 31, 11, 255);
        drain();

        set_masks('1, '1, '1, 31'd1 << 28, 12'd2, 7'h7f);
        send_start(0, 0, 0, 1, 0, 96);
        send_start(0, 0, 0, 1, 2, 100);
        drain();

        set_masks('1, '1, '1, '1, '1, '1);
        write_mask(cnts_pkg::REG_SECOND_MASK, '0);
        send_start(1, 2, 3, 4, 5, 6);
        drain();
        write_mask(cnts_pkg::REG_SECOND_MASK, '1);
        write_mask(cnts_pkg::REG_MINUTE_MASK, '0);
        send_start(1, 2, 3, 4, 5, 6);
        drain();
        write_mask(cnts_pkg::REG_MINUTE_MASK, '1);
        write_mask(cnts_pkg::REG_HOUR_MASK, '0);
        send_start(1, 2, 3, 4, 5, 6);
        drain();
        set_masks('1, '1, '1, '0, '1, '1);
        send_start(0, 0, 0, 1, 0, 200);
        drain();
        set_masks('1, '1, '1, '1, '0, '1);
        send_start(0, 0, 0, 1, 0, 250);
        drain();
        set_masks('1, '1, '1, '1, '1, '0);
        send_start(0, 0, 0, 1, 0, 254);
        drain();
        write_mask(REG_SPARE_LO, {$urandom, $urandom});
        write_mask(REG_SPARE_HI, {$urandom, $urandom});

        for (int ph = 0; ph < 4; ph++) begin
            set_masks(some_bits(60), some_bits(60), some_bits(24), some_bits(31),
                      some_bits(12), some_bits(7));
            repeat (20) send_random();
            drain();
        end

        quiet = 1;
        set_masks('1, '1, '1, '1, '1, '1);
        repeat (20) send_random();
        s_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (errors == 0 && pending == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial begin
        #1_500_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
